FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the axis step core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is active.
`define CAAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("caas: implication check failed");

// Condition that must never hold while out of reset.
`define CAAS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("caas: forbidden condition seen");

`endif

FILE: hw/rtl/caas_pkg.sv
// Types, widths and a helper function shared by the axis step core.
package caas_pkg;

	localparam int AXIS_W = 3;
	localparam int Q_W    = 32;
	localparam int GAIN_W = 20;
	localparam int COEF_W = 60;
	localparam int DT_W   = 24;

	localparam logic [DT_W-1:0]   DT_RESET   = 24'd16777;
	localparam logic [AXIS_W-1:0] TRANS_AXES = 3'd3;

	localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [GAIN_W-1:0] stiffness;
		logic signed [GAIN_W-1:0] damping;
		logic signed [GAIN_W-1:0] force_gain;
	} caas_gain_t;

	typedef struct packed {
		logic signed [Q_W-1:0] value;
		logic                  clipped;
	} caas_clip_t;

	// Clamp a wide signed value into Q16.16 and flag the clip.
	function automatic caas_clip_t clip_q(input logic signed [63:0] x);
		caas_clip_t r;
		if (x > Q_MAX) begin
			r.value   = Q_MAX[Q_W-1:0];
			r.clipped = 1'b1;
		end else if (x < Q_MIN) begin
			r.value   = Q_MIN[Q_W-1:0];
			r.clipped = 1'b1;
		end else begin
			r.value   = x[Q_W-1:0];
			r.clipped = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/caas_cfg.sv
// Coefficient and step period registers with per-axis gain selection.
module caas_cfg #(
	parameter int NUM_AXES = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [$clog2(NUM_AXES+1)-1:0]      wr_index,
	input  logic [caas_pkg::COEF_W-1:0]        wr_data,
	input  logic [caas_pkg::AXIS_W-1:0]        axis,
	output caas_pkg::caas_gain_t               gain,
	output logic [caas_pkg::DT_W-1:0]          dt
);

	localparam int IDX_W = $clog2(NUM_AXES + 1);

	logic [caas_pkg::COEF_W-1:0] coef_q [NUM_AXES];
	logic [caas_pkg::DT_W-1:0]   dt_q;
	logic [caas_pkg::COEF_W-1:0] sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				coef_q[i] <= '0;
			end
			dt_q <= caas_pkg::DT_RESET;
		end else if (wr_en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				if (wr_index == IDX_W'(i)) begin
					coef_q[i] <= wr_data;
				end
			end
			if (wr_index == IDX_W'(NUM_AXES)) begin
				dt_q <= wr_data[caas_pkg::DT_W-1:0];
			end
		end
	end

	// Axis without a register reads as all-zero gains.
	always_comb begin
		sel = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (int'(axis) == i) begin
				sel = coef_q[i];
			end
		end
	end

	assign gain.stiffness  = $signed(sel[59:40]);
	assign gain.damping    = $signed(sel[39:20]);
	assign gain.force_gain = $signed(sel[19:0]);
	assign dt              = dt_q;

endmodule

FILE: hw/rtl/cartesian_admittance_axis_step_core.sv
// Top level of the per-axis second-order admittance step pipeline.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | axis, pose/speed/force error, actual speed/pose
//  out     | out_valid / out_ready| axis_out, command_speed, pose_step, command_pose,
//          |                      | saturated
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// Eight register stages: gain products, sum and round, split dt products,
// recombine, speed clip, second dt product, step round/clip, pose/output.
// One item per cycle while out_ready holds; items pass the stage registers in order.
// Each stage loads when empty or when the next one moves, so bubbles fill during
// an output stall. Reset clears all valid bits, zeroes the gains and sets dt to
// about one millisecond.
`include "assert_macros.svh"

module cartesian_admittance_axis_step_core #(
	parameter int NUM_AXES = 6
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [caas_pkg::AXIS_W-1:0]             axis,
	input  logic signed [caas_pkg::Q_W-1:0]         pose_error,
	input  logic signed [caas_pkg::Q_W-1:0]         speed_error,
	input  logic signed [caas_pkg::Q_W-1:0]         force_error,
	input  logic signed [caas_pkg::Q_W-1:0]         actual_speed,
	input  logic signed [caas_pkg::Q_W-1:0]         actual_pose,

	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [caas_pkg::AXIS_W-1:0]             axis_out,
	output logic signed [caas_pkg::Q_W-1:0]         command_speed,
	output logic signed [caas_pkg::Q_W-1:0]         pose_step,
	output logic signed [caas_pkg::Q_W-1:0]         command_pose,
	output logic                                    saturated,

	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [$clog2(NUM_AXES+1)-1:0]           cfg_index,
	input  logic [caas_pkg::COEF_W-1:0]             cfg_data
);

	localparam int PROD_W = caas_pkg::GAIN_W + caas_pkg::Q_W;  // 52
	localparam int SUM_W  = PROD_W + 2;                        // 54
	localparam int ACC_W  = SUM_W - 12;                        // 42
	localparam int HALF_W = ACC_W / 2;                         // 21
	localparam int PH_W   = HALF_W + caas_pkg::DT_W + 1;       // 46
	localparam int PL_W   = HALF_W + caas_pkg::DT_W;           // 45
	localparam int FULL_W = PH_W + HALF_W + 1;                 // 68
	localparam int M1_W   = FULL_W - caas_pkg::DT_W;           // 44
	localparam int DIFF_W = M1_W + 1;                          // 45
	localparam int P2_W   = caas_pkg::Q_W + caas_pkg::DT_W + 1; // 57
	localparam int STP_W  = P2_W - caas_pkg::DT_W;             // 33

	caas_pkg::caas_gain_t          gain;
	logic [caas_pkg::DT_W-1:0]     dt;
	logic signed [caas_pkg::DT_W:0] dt_s;

	logic [8:1] adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic [caas_pkg::AXIS_W-1:0] axis_s1, axis_s2, axis_s3, axis_s4;
	logic [caas_pkg::AXIS_W-1:0] axis_s5, axis_s6, axis_s7, axis_s8;
	logic signed [caas_pkg::Q_W-1:0] as_s1, as_s2, as_s3, as_s4;
	logic signed [caas_pkg::Q_W-1:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7;

	logic signed [PROD_W-1:0] prod_k_s1, prod_d_s1, prod_g_s1;
	logic signed [SUM_W-1:0]  rnd_w;
	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [PH_W-1:0]   ph_s3;
	logic [PL_W-1:0]          pl_s3;
	logic signed [FULL_W-1:0] full_w;
	logic signed [M1_W-1:0]   m1_s4;
	logic signed [DIFF_W-1:0] diff_w;
	caas_pkg::caas_clip_t     spd_clip;
	logic signed [caas_pkg::Q_W-1:0] spd_s5, spd_s6, spd_s7, spd_s8;
	logic sat_s5, sat_s6, sat_s7, sat_s8;
	logic signed [P2_W-1:0]   p2_s6;
	logic signed [P2_W-1:0]   r2_w;
	caas_pkg::caas_clip_t     stp_clip;
	logic signed [caas_pkg::Q_W-1:0] stp_s7, stp_s8, pose_s8;
	caas_pkg::caas_clip_t     pose_clip;

	caas_cfg #(
		.NUM_AXES(NUM_AXES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.axis     (axis),
		.gain     (gain),
		.dt       (dt)
	);

	assign cfg_ready = 1'b1;
	assign dt_s      = $signed({1'b0, dt});

	// A stage moves when it is empty or its successor moves.
	always_comb begin
		adv[8] = !vld_s8 || out_ready;
		adv[7] = !vld_s7 || adv[8];
		adv[6] = !vld_s6 || adv[7];
		adv[5] = !vld_s5 || adv[6];
		adv[4] = !vld_s4 || adv[5];
		adv[3] = !vld_s3 || adv[4];
		adv[2] = !vld_s2 || adv[3];
		adv[1] = !vld_s1 || adv[2];
	end

	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= in_valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
			if (adv[8]) vld_s8 <= vld_s7;
		end
	end

	// Stage 1: the three gain products, exact in Q.28.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			axis_s1   <= axis;
			as_s1     <= actual_speed;
			ap_s1     <= actual_pose;
			prod_k_s1 <= PROD_W'(gain.stiffness) * PROD_W'(pose_error);
			prod_d_s1 <= PROD_W'(gain.damping) * PROD_W'(speed_error);
			prod_g_s1 <= PROD_W'(gain.force_gain) * PROD_W'(force_error);
		end
	end

	// Stage 2: sum and round to Q.16 (floor after adding half an lsb).
	assign rnd_w = SUM_W'(prod_k_s1) + SUM_W'(prod_d_s1) + SUM_W'(prod_g_s1)
		+ SUM_W'(2048);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			axis_s2 <= axis_s1;
			as_s2   <= as_s1;
			ap_s2   <= ap_s1;
			acc_s2  <= rnd_w[SUM_W-1:12];
		end
	end

	// Stage 3: accel times dt, split into signed high and unsigned low halves.
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			axis_s3 <= axis_s2;
			as_s3   <= as_s2;
			ap_s3   <= ap_s2;
			ph_s3   <= PH_W'($signed(acc_s2[ACC_W-1:HALF_W])) * PH_W'(dt_s);
			pl_s3   <= PL_W'(acc_s2[HALF_W-1:0]) * PL_W'(dt);
		end
	end

	// Stage 4: recombine the halves and round off 24 bits.
	assign full_w = (FULL_W'(ph_s3) <<< HALF_W) + $signed(FULL_W'(pl_s3))
		+ FULL_W'(64'sh800000);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			axis_s4 <= axis_s3;
			as_s4   <= as_s3;
			ap_s4   <= ap_s3;
			m1_s4   <= full_w[FULL_W-1:caas_pkg::DT_W];
		end
	end

	// Stage 5: command speed, clipped.
	assign diff_w   = DIFF_W'(as_s4) - DIFF_W'(m1_s4);
	assign spd_clip = caas_pkg::clip_q(64'(diff_w));

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			axis_s5 <= axis_s4;
			ap_s5   <= ap_s4;
			spd_s5  <= spd_clip.value;
			sat_s5  <= spd_clip.clipped;
		end
	end

	// Stage 6: clipped speed times dt.
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			axis_s6 <= axis_s5;
			ap_s6   <= ap_s5;
			spd_s6  <= spd_s5;
			sat_s6  <= sat_s5;
			p2_s6   <= P2_W'(spd_s5) * P2_W'(dt_s);
		end
	end

	// Stage 7: round and clip the pose step.
	assign r2_w     = p2_s6 + P2_W'(64'sh800000);
	assign stp_clip = caas_pkg::clip_q(64'($signed(r2_w[P2_W-1:caas_pkg::DT_W])));

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			axis_s7 <= axis_s6;
			ap_s7   <= ap_s6;
			spd_s7  <= spd_s6;
			stp_s7  <= stp_clip.value;
			sat_s7  <= sat_s6 || stp_clip.clipped;
		end
	end

	// Stage 8: translational axes add the step to the pose; rotational pass it.
	assign pose_clip = caas_pkg::clip_q(64'(ap_s7) + 64'(stp_s7));

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			axis_s8 <= axis_s7;
			spd_s8  <= spd_s7;
			stp_s8  <= stp_s7;
			if (axis_s7 < caas_pkg::TRANS_AXES) begin
				pose_s8 <= pose_clip.value;
				sat_s8  <= sat_s7 || pose_clip.clipped;
			end else begin
				pose_s8 <= stp_s7;
				sat_s8  <= sat_s7;
			end
		end
	end

	assign out_valid     = vld_s8;
	assign axis_out      = axis_s8;
	assign command_speed = spd_s8;
	assign pose_step     = stp_s8;
	assign command_pose  = pose_s8;
	assign saturated     = sat_s8;

	`CAAS_ASSERT_IMPLY(a_rot_pose_is_step, clk, arst_n,
		out_valid && !(axis_out < caas_pkg::TRANS_AXES), command_pose == pose_step)
	`CAAS_ASSERT_IMPLY(a_ready_follows_out, clk, arst_n, out_ready, in_ready)
	`CAAS_ASSERT_NEVER(a_out_from_nowhere, clk, arst_n, $rose(out_valid) && !$past(vld_s7))

endmodule
